// File: design/heater_overshoot_test_sequencer_top_defines.svh
// assertion macros for the heater overshoot test sequencer checker
// no dependencies; included by the checker file only
`ifndef HEATER_OVERSHOOT_TEST_SEQUENCER_TOP_DEFINES_SVH
`define HEATER_OVERSHOOT_TEST_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HOS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hos_pkg.sv
// shared types, codes and constants of the heater overshoot test sequencer
// no dependencies
package hos_pkg;

    localparam int PointCount = 4;

    localparam int TempW  = 13;
    localparam int TimeW  = 32;
    localparam int DcW    = 11;
    localparam int DutyW  = 7;
    localparam int CountW = 8;
    localparam int CodeW  = 3;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;
    localparam int InDataW  = 48;
    localparam int OutDataW = 88;

    localparam logic [DutyW-1:0]  DutyMax  = 7'd100;
    localparam logic [CountW-1:0] CountMax = 8'd255;

    // configuration register indexes
    localparam logic [2:0] REG_COOL_LIMIT = 3'd0;
    localparam logic [2:0] REG_DUTY       = 3'd1;
    localparam logic [2:0] REG_CONFIRM    = 3'd2;
    localparam logic [2:0] REG_CUTOFF_0   = 3'd3;
    localparam logic [2:0] REG_CUTOFF_1   = 3'd4;
    localparam logic [2:0] REG_CUTOFF_2   = 3'd5;
    localparam logic [2:0] REG_CUTOFF_3   = 3'd6;

    // phase codes as seen on the output
    localparam logic [CodeW-1:0] PHASE_WAIT_CODE   = 3'd0;
    localparam logic [CodeW-1:0] PHASE_HEAT_CODE   = 3'd1;
    localparam logic [CodeW-1:0] PHASE_RUNOUT_CODE = 3'd2;
    localparam logic [CodeW-1:0] PHASE_PEAK_CODE   = 3'd3;
    localparam logic [CodeW-1:0] PHASE_DONE_CODE   = 3'd4;

    typedef enum logic [4:0] {
        PH_WAIT   = 5'b00001,
        PH_HEAT   = 5'b00010,
        PH_RUNOUT = 5'b00100,
        PH_PEAK   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef enum logic [CodeW-1:0] {
        EV_NONE     = 3'd0,
        EV_DOOR     = 3'd1,
        EV_START    = 3'd2,
        EV_OFF      = 3'd3,
        EV_RESULT   = 3'd4,
        EV_NEXT     = 3'd5,
        EV_COMPLETE = 3'd6
    } t_event;

    typedef struct packed {
        logic [DcW-1:0]                  cool_limit;
        logic [DutyW-1:0]                duty;
        logic [CountW-1:0]               confirm;
        logic [PointCount-1:0][DcW-1:0]  cutoff;
    } t_cfg;

    typedef struct packed {
        logic                    heat_cmd;
        logic [DutyW-1:0]        heater_duty;
        logic [CodeW-1:0]        phase;
        logic [CodeW-1:0]        run_number;
        t_event                  event_res;
        logic signed [TempW-1:0] temp_at_off;
        logic signed [TempW-1:0] peak_temp;
        logic [TempW-1:0]        overshoot;
        logic [TimeW-1:0]        rise_time;
    } t_result;

    function automatic logic [CodeW-1:0] phase_code(input t_phase ph);
        logic [CodeW-1:0] code;
        unique case (ph)
            PH_WAIT:   code = PHASE_WAIT_CODE;
            PH_HEAT:   code = PHASE_HEAT_CODE;
            PH_RUNOUT: code = PHASE_RUNOUT_CODE;
            PH_PEAK:   code = PHASE_PEAK_CODE;
            default:   code = PHASE_DONE_CODE;
        endcase
        return code;
    endfunction

endpackage

// File: design/hos_cfg.sv
// configuration register file with its APB-style access port
// depends on hos_pkg
module hos_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hos_pkg::AddrW-1:0] paddr,
    input  logic [hos_pkg::DataW-1:0] pwdata,
    output logic [hos_pkg::DataW-1:0] prdata,
    output hos_pkg::t_cfg             o_cfg
);
    import hos_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cool_limit <= 11'd280;
            r_cfg.duty       <= 7'd50;
            r_cfg.confirm    <= 8'd8;
            r_cfg.cutoff[0]  <= 11'd350;
            r_cfg.cutoff[1]  <= 11'd370;
            r_cfg.cutoff[2]  <= 11'd390;
            r_cfg.cutoff[3]  <= 11'd410;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COOL_LIMIT: r_cfg.cool_limit <= pwdata[DcW-1:0];
                REG_DUTY:       r_cfg.duty       <= pwdata[DutyW-1:0];
                REG_CONFIRM:    r_cfg.confirm    <= pwdata[CountW-1:0];
                REG_CUTOFF_0:   r_cfg.cutoff[0]  <= pwdata[DcW-1:0];
                REG_CUTOFF_1:   r_cfg.cutoff[1]  <= pwdata[DcW-1:0];
                REG_CUTOFF_2:   r_cfg.cutoff[2]  <= pwdata[DcW-1:0];
                REG_CUTOFF_3:   r_cfg.cutoff[3]  <= pwdata[DcW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COOL_LIMIT: prdata = DataW'(r_cfg.cool_limit);
            REG_DUTY:       prdata = DataW'(r_cfg.duty);
            REG_CONFIRM:    prdata = DataW'(r_cfg.confirm);
            REG_CUTOFF_0:   prdata = DataW'(r_cfg.cutoff[0]);
            REG_CUTOFF_1:   prdata = DataW'(r_cfg.cutoff[1]);
            REG_CUTOFF_2:   prdata = DataW'(r_cfg.cutoff[2]);
            REG_CUTOFF_3:   prdata = DataW'(r_cfg.cutoff[3]);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/hos_core.sv
// test sequencer state and per-sample next-state and result logic
// depends on hos_pkg
module hos_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [hos_pkg::TimeW-1:0]        i_now_ms,
    input  logic                             i_door_ajar,
    input  logic                             i_temp_valid,
    input  logic signed [hos_pkg::TempW-1:0] i_chamber_temp_dc,
    input  hos_pkg::t_cfg                    i_cfg,
    output hos_pkg::t_result                 o_result
);
    import hos_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [CodeW-1:0]        r_run, n_run;
    logic                    r_heater, n_heater;
    logic [TimeW-1:0]        r_off_time, n_off_time;
    logic signed [TempW-1:0] r_off_temp, n_off_temp;
    logic signed [TempW-1:0] r_peak_temp, n_peak_temp;
    logic [TimeW-1:0]        r_peak_time, n_peak_time;
    logic [CountW-1:0]       r_fall, n_fall;

    logic signed [TempW:0]   temp_x, reset_x, point_x, over_x;
    logic [CodeW-1:0]        run_inc;
    t_event                  ev;
    logic signed [TempW-1:0] res_off, res_peak;
    logic [TempW-1:0]        res_over;
    logic [TimeW-1:0]        res_ttp;

    assign temp_x  = (TempW+1)'(i_chamber_temp_dc);
    assign reset_x = $signed({3'b000, i_cfg.cool_limit});
    assign point_x = $signed({3'b000, i_cfg.cutoff[r_run[1:0]]});
    assign run_inc = r_run + 3'd1;

    always_comb begin
        n_phase     = r_phase;
        n_run       = r_run;
        n_heater    = r_heater;
        n_off_time  = r_off_time;
        n_off_temp  = r_off_temp;
        n_peak_temp = r_peak_temp;
        n_peak_time = r_peak_time;
        n_fall      = r_fall;
        ev          = EV_NONE;
        res_off     = '0;
        res_peak    = '0;
        res_over    = '0;
        res_ttp     = '0;
        over_x      = '0;

        if (i_door_ajar) begin
            // door forces the heater off and restarts the current run
            n_heater = 1'b0;
            if (r_phase != PH_WAIT) begin
                n_phase = PH_WAIT;
                ev      = EV_DOOR;
            end
        end else if (!i_temp_valid) begin
            // not a number: hold everything
        end else if (r_run >= CodeW'(PointCount)) begin
            n_heater = 1'b0;
            n_phase  = PH_DONE;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (temp_x <= reset_x) begin
                        n_phase  = PH_HEAT;
                        n_heater = 1'b1;
                        ev       = EV_START;
                    end
                end
                PH_HEAT: begin
                    if (temp_x >= point_x) begin
                        n_heater    = 1'b0;
                        n_off_time  = i_now_ms;
                        n_off_temp  = i_chamber_temp_dc;
                        n_peak_temp = i_chamber_temp_dc;
                        n_peak_time = i_now_ms;
                        n_fall      = '0;
                        n_phase     = PH_RUNOUT;
                        ev          = EV_OFF;
                    end
                end
                PH_RUNOUT: begin
                    if (i_chamber_temp_dc > r_peak_temp) begin
                        n_peak_temp = i_chamber_temp_dc;
                        n_peak_time = i_now_ms;
                        n_fall      = '0;
                    end else if (i_chamber_temp_dc < r_peak_temp && r_fall != CountMax) begin
                        n_fall = r_fall + 8'd1;
                    end
                    if (n_fall >= i_cfg.confirm) begin
                        over_x   = (TempW+1)'(n_peak_temp) - (TempW+1)'(r_off_temp);
                        res_off  = r_off_temp;
                        res_peak = n_peak_temp;
                        res_over = over_x[TempW-1:0];
                        res_ttp  = (n_peak_time >= r_off_time) ?
                                   (n_peak_time - r_off_time) : '0;
                        n_phase  = PH_PEAK;
                        ev       = EV_RESULT;
                    end
                end
                PH_PEAK: begin
                    n_run = run_inc;
                    if (run_inc < CodeW'(PointCount)) begin
                        n_phase = PH_WAIT;
                        ev      = EV_NEXT;
                    end else begin
                        n_phase = PH_DONE;
                        ev      = EV_COMPLETE;
                    end
                end
                default: begin
                    n_heater = 1'b0;
                    n_phase  = PH_DONE;
                end
            endcase
        end
    end

    always_comb begin
        o_result.heat_cmd     = n_heater;
        o_result.heater_duty  = n_heater ?
                                ((i_cfg.duty > DutyMax) ? DutyMax : i_cfg.duty) : '0;
        o_result.phase        = phase_code(n_phase);
        o_result.run_number   = (n_run < CodeW'(PointCount)) ?
                                (n_run + 3'd1) : CodeW'(PointCount);
        o_result.event_res    = ev;
        o_result.temp_at_off  = res_off;
        o_result.peak_temp    = res_peak;
        o_result.overshoot    = res_over;
        o_result.rise_time    = res_ttp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_run    <= '0;
            r_heater <= 1'b0;
            r_fall   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_run    <= n_run;
            r_heater <= n_heater;
            r_fall   <= n_fall;
        end
    end

    // run data is always loaded at switch-off before it is read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_off_time  <= n_off_time;
            r_off_temp  <= n_off_temp;
            r_peak_temp <= n_peak_temp;
            r_peak_time <= n_peak_time;
        end
    end

endmodule

// File: design/heater_overshoot_test_sequencer_top.sv
// Heater overshoot test sequencer, top level. Each chamber sample request yields
// exactly one result request, which shows on the output the cycle after the sample
// is taken, or later while earlier results are stalled. A sample is taken in
// every cycle while the two-entry output buffer has room, so the sustained rate
// is one sample per clock; the sequencer state updates in a single step between
// the sample handshake and the output register. The test walks four switch-off
// points: wait until the chamber is at or below the reset temperature, heat at
// the programmed duty up to the switch-off point, then follow the runout peak
// and report overshoot and time to peak once enough falling samples are seen.
// An open door kills the heater and restarts the current point; a sample flagged
// invalid changes nothing unless the door is open. Registers are written over the
// APB-style port and should only be changed while no sample is in flight.
// depends on hos_pkg, hos_cfg, hos_core
module heater_overshoot_test_sequencer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample requests
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [31:0] now_ms, [32] door_ajar, [45:33] chamber_temp_dc, rest zero
    input  logic [hos_pkg::InDataW-1:0]  s_tdata,
    // [0] temp_valid
    input  logic [0:0]                   s_tuser,
    // result requests
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] heat_cmd, [7:1] heater_duty, [10:8] phase, [13:11] run_number,
    // [26:14] temp_at_off_dc, [39:27] peak_temp_dc, [52:40] overshoot_dc,
    // [84:53] rise_time_ms, rest zero
    output logic [hos_pkg::OutDataW-1:0] m_tdata,
    // [2:0] event_res
    output logic [2:0]                   m_tuser,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hos_pkg::AddrW-1:0]    paddr,
    input  logic [hos_pkg::DataW-1:0]    pwdata,
    output logic [hos_pkg::DataW-1:0]    prdata,
    output logic                         pready
);
    import hos_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    logic    in_accept;
    logic    out_take;

    // output register plus one skid entry
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign pready = 1'b1;

    hos_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // ready depends only on the skid entry, so a stalled result never blocks
    // the next sample while the output register is still occupied
    assign s_tready  = !r_skid_valid;
    assign in_accept = s_tvalid && s_tready;
    assign out_take  = r_out_valid && m_tready;

    hos_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_now_ms          (s_tdata[31:0]),
        .i_door_ajar       (s_tdata[32]),
        .i_temp_valid      (s_tuser[0]),
        .i_chamber_temp_dc (s_tdata[45:33]),
        .i_cfg             (cfg),
        .o_result          (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            // output slot frees up: refill from skid first, else from the core
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= core_res;
            end
        end else if (in_accept) begin
            r_skid <= core_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.event_res;
    assign m_tdata  = {3'b000,
                       r_out.rise_time,
                       r_out.overshoot,
                       r_out.peak_temp,
                       r_out.temp_at_off,
                       r_out.run_number,
                       r_out.phase,
                       r_out.heater_duty,
                       r_out.heat_cmd};

endmodule

// File: design/hos_checker.sv
// port-level checker for the heater overshoot test sequencer, with its bind
// depends on hos_pkg and heater_overshoot_test_sequencer_top_defines.svh
`include "heater_overshoot_test_sequencer_top_defines.svh"

module hos_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [hos_pkg::OutDataW-1:0] m_tdata,
    input logic [2:0]                   m_tuser
);
    import hos_pkg::*;

    logic             heat_cmd;
    logic [DutyW-1:0] heater_duty;
    logic [CodeW-1:0] phase;
    logic [CodeW-1:0] run_number;

    assign heat_cmd    = m_tdata[0];
    assign heater_duty = m_tdata[7:1];
    assign phase       = m_tdata[10:8];
    assign run_number  = m_tdata[13:11];

    // stalled result holds
    `HOS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // duty only while the heater is on
    `HOS_ASSERT_SAME(a_duty_off, i_clk, i_rst_n, m_tvalid && !heat_cmd,
        heater_duty == '0, "duty nonzero with heater off")

    // a result is reported on entry to peak reached
    `HOS_ASSERT_SAME(a_result_phase, i_clk, i_rst_n, m_tvalid && m_tuser == EV_RESULT,
        phase == PHASE_PEAK_CODE && !heat_cmd, "result event outside peak phase")

    // a run start turns the heater on in the heating phase
    `HOS_ASSERT_SAME(a_start_heat, i_clk, i_rst_n, m_tvalid && m_tuser == EV_START,
        heat_cmd && phase == PHASE_HEAT_CODE, "run start without heating")

    // complete means heater off on the last point
    `HOS_ASSERT_SAME(a_done, i_clk, i_rst_n, m_tvalid && phase == PHASE_DONE_CODE,
        !heat_cmd && run_number == CodeW'(PointCount), "complete phase inconsistent")

endmodule

bind heater_overshoot_test_sequencer_top hos_checker u_hos_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
